FILE: rtl/core/tpll_pkg.sv
// Shared types and constants for the thermal PID light limiter.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tpll_pkg;

	// Field and register widths that do not follow from the module parameters.
	localparam int LEVEL_W   = 16;
	localparam int LIMIT_W   = 16;
	localparam int DT_W      = 16;
	localparam int INV_W     = 24;
	localparam int INTEG_W   = 28;
	localparam int UNIT_W    = 48;
	localparam int DIGIT_W   = 16;
	localparam int CFG_IDX_W = 3;

	// Reset values of the configuration registers and the held limit.
	localparam int TARGET_RST = 15360;
	localparam int ACT_RST    = 32768;
	localparam int DT_RST     = 65;
	localparam int INV_RST    = 1048576;
	localparam int LIMIT_ONE  = 32768;

	// Integral clamp: 500 degree-seconds in Q16.16.
	localparam int INTEG_LIMIT = 32768000;

	// PID sum bounds and saturation limits, all Q32.32.
	localparam logic signed [63:0] SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_MIN   = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] UNITY     = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] PID_LOW   = -64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] PID_HIGH  = 64'sh0000_8000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 3'd0,
		REG_ACT    = 3'd1,
		REG_KP     = 3'd2,
		REG_KI     = 3'd3,
		REG_KD     = 3'd4,
		REG_DT     = 3'd5,
		REG_INV_DT = 3'd6
	} cfg_reg_t;

	// Operations run through the shared multiplier, in the order they are issued.
	typedef enum logic [2:0] {
		OP_INC = 3'd0,  // error times dt, added into the integral
		OP_DRV = 3'd1,  // difference of errors times 1/dt
		OP_PRP = 3'd2,  // proportional term
		OP_INT = 3'd3,  // integral term
		OP_DER = 3'd4,  // derivative term
		OP_LIM = 3'd5   // held limit times (1 + pid)
	} op_t;

	typedef struct packed {
		logic take;
		logic load;
		logic step;
		logic write;
		logic emit;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tpll_ctrl.sv
// Controller state machine of the thermal PID light limiter.
// Sequences the multiplier operations and the output register; uses tpll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpll_ctrl #(
	parameter int NUM_DIGITS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  tpll_pkg::dp_status_t  status,
	output tpll_pkg::dp_cmd_t     cmd
);
	import tpll_pkg::*;

	localparam int CW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_LOAD  = 5'b00010,
		S_STEP  = 5'b00100,
		S_WRITE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t         state_q, state_d;
	op_t            op_q, op_d;
	logic [CW-1:0]  digit_q, digit_d;
	logic           out_valid_q;

	function automatic op_t next_op(input op_t op);
		case (op)
			OP_INC:  next_op = OP_DRV;
			OP_DRV:  next_op = OP_PRP;
			OP_PRP:  next_op = OP_INT;
			OP_INT:  next_op = OP_DER;
			OP_DER:  next_op = OP_LIM;
			default: next_op = OP_LIM;
		endcase
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		digit_d   = digit_q;
		cmd       = '0;
		cmd.op    = op_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					op_d     = OP_INC;
					state_d  = S_LOAD;
				end
			end
			S_LOAD: begin
				// Below the activation level nothing is computed.
				if (status.skip) begin
					state_d = S_DONE;
				end else begin
					cmd.load = 1'b1;
					digit_d  = CW'(NUM_DIGITS - 1);
					state_d  = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (digit_q == '0) begin
					state_d = S_WRITE;
				end else begin
					digit_d = digit_q - 1'b1;
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				if (op_q == OP_LIM) begin
					state_d = S_DONE;
				end else begin
					op_d    = next_op(op_q);
					state_d = S_LOAD;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_INC;
			digit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			digit_q <= digit_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/tpll_datapath.sv
// Datapath of the thermal PID light limiter: configuration registers, loop
// state, one shared digit-serial multiplier and the output register. Uses tpll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpll_datapath #(
	parameter int TEMP_WIDTH = 16,
	parameter int GAIN_WIDTH = 32,
	parameter int NUM_DIGITS = 2,
	parameter int CFG_W      = 32,
	parameter int IN_W       = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tpll_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data,
	input  logic [IN_W-1:0]                   s_tdata,
	input  tpll_pkg::dp_cmd_t                 cmd,
	output tpll_pkg::dp_status_t              status,
	output logic [tpll_pkg::LIMIT_W-1:0]      m_tdata,
	output logic                              m_tuser
);
	import tpll_pkg::*;

	localparam int TW  = TEMP_WIDTH;
	localparam int GW  = GAIN_WIDTH;
	localparam int EW  = TW + 1;         // error
	localparam int DW  = EW + 3;         // three-point difference
	localparam int DRW = EW + 26;        // derivative, Q.16
	localparam int AW  = (DRW > UNIT_W) ? DRW : UNIT_W;
	localparam int BPW = NUM_DIGITS * DIGIT_W;
	localparam int PW  = AW + BPW;       // product magnitude
	localparam int RW  = PW + 1;         // signed product
	localparam int PRW = RW + 8;         // proportional product scaled by 2^8
	localparam int SW  = RW + 1;         // integral sum
	localparam int LW  = PW - 32;        // limit product after dropping Q32 bits

	localparam logic signed [SW-1:0] ILIM_P = SW'(INTEG_LIMIT);
	localparam logic signed [SW-1:0] ILIM_N = -ILIM_P;

	// Configuration registers.
	logic signed [TW-1:0]     target_q;
	logic [LEVEL_W-1:0]       act_q;
	logic signed [GW-1:0]     kp_q, ki_q, kd_q;
	logic [DT_W-1:0]          dt_q;
	logic [INV_W-1:0]         inv_q;

	// Latched sample.
	logic signed [TW-1:0]     temp_q;
	logic [LEVEL_W-1:0]       level_q;

	// Loop state.
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [EW-1:0]      last_q, before_q;
	logic [1:0]                hist_q;
	logic [LIMIT_W-1:0]        held_q;

	// Working registers.
	logic signed [63:0]        pid_q;
	logic signed [DRW-1:0]     deriv_q;
	logic [AW-1:0]             a_q;
	logic [BPW-1:0]            b_q;
	logic                      neg_q;
	logic [PW-1:0]             acc_q;
	logic [LIMIT_W-1:0]        out_limit_q;
	logic                      out_upd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TW'(TARGET_RST);
			act_q    <= LEVEL_W'(ACT_RST);
			kp_q     <= '0;
			ki_q     <= '0;
			kd_q     <= '0;
			dt_q     <= DT_W'(DT_RST);
			inv_q    <= INV_W'(INV_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET: target_q <= cfg_data[TW-1:0];
				REG_ACT:    act_q    <= cfg_data[LEVEL_W-1:0];
				REG_KP:     kp_q     <= cfg_data[GW-1:0];
				REG_KI:     ki_q     <= cfg_data[GW-1:0];
				REG_KD:     kd_q     <= cfg_data[GW-1:0];
				REG_DT:     dt_q     <= cfg_data[DT_W-1:0];
				REG_INV_DT: inv_q    <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			temp_q  <= s_tdata[TW-1:0];
			level_q <= s_tdata[TW+LEVEL_W-1:TW];
		end
	end

	assign status.skip = (level_q < act_q);

	// Error and the backward differences.
	logic signed [EW-1:0] err;
	logic signed [DW-1:0] err_x, last_x, bef_x, diff1, diff2, diff;

	assign err    = $signed({target_q[TW-1], target_q}) - $signed({temp_q[TW-1], temp_q});
	assign err_x  = {{(DW-EW){err[EW-1]}}, err};
	assign last_x = {{(DW-EW){last_q[EW-1]}}, last_q};
	assign bef_x  = {{(DW-EW){before_q[EW-1]}}, before_q};
	assign diff1  = err_x - last_x;
	assign diff2  = (err_x <<< 1) + err_x - (last_x <<< 2) + bef_x;
	assign diff   = hist_q[1] ? diff2 : (hist_q[0] ? diff1 : '0);

	// Magnitudes of the signed multiplier operands.
	logic [EW-1:0]      err_mag;
	logic [DW-1:0]      diff_mag;
	logic [INTEG_W-1:0] integ_mag;
	logic [DRW-1:0]     deriv_mag;
	logic [GW-1:0]      kp_mag, ki_mag, kd_mag;

	assign err_mag   = err[EW-1]       ? (~err + 1'b1)     : err;
	assign diff_mag  = diff[DW-1]      ? (~diff + 1'b1)    : diff;
	assign integ_mag = integ_q[INTEG_W-1] ? (~integ_q + 1'b1) : integ_q;
	assign deriv_mag = deriv_q[DRW-1]  ? (~deriv_q + 1'b1) : deriv_q;
	assign kp_mag    = kp_q[GW-1]      ? (~kp_q + 1'b1)    : kp_q;
	assign ki_mag    = ki_q[GW-1]      ? (~ki_q + 1'b1)    : ki_q;
	assign kd_mag    = kd_q[GW-1]      ? (~kd_q + 1'b1)    : kd_q;

	// The PID sum is clamped to [-1, 32768] before it scales the held limit.
	logic signed [63:0] pid_c;
	logic [63:0]        u_full;

	assign pid_c  = (pid_q < PID_LOW) ? PID_LOW : ((pid_q > PID_HIGH) ? PID_HIGH : pid_q);
	assign u_full = pid_c + UNITY;

	logic [AW-1:0]  op_a;
	logic [BPW-1:0] op_b;
	logic           op_neg;

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_neg = 1'b0;
		case (cmd.op)
			OP_INC: begin
				op_a   = AW'(err_mag);
				op_b   = BPW'(dt_q);
				op_neg = err[EW-1];
			end
			OP_DRV: begin
				op_a   = AW'(diff_mag);
				op_b   = BPW'(inv_q);
				op_neg = diff[DW-1];
			end
			OP_PRP: begin
				op_a   = AW'(err_mag);
				op_b   = BPW'(kp_mag);
				op_neg = err[EW-1] ^ kp_q[GW-1];
			end
			OP_INT: begin
				op_a   = AW'(integ_mag);
				op_b   = BPW'(ki_mag);
				op_neg = integ_q[INTEG_W-1] ^ ki_q[GW-1];
			end
			OP_DER: begin
				op_a   = AW'(deriv_mag);
				op_b   = BPW'(kd_mag);
				op_neg = deriv_q[DRW-1] ^ kd_q[GW-1];
			end
			OP_LIM: begin
				op_a   = AW'(u_full[UNIT_W-1:0]);
				op_b   = BPW'(held_q);
				op_neg = 1'b0;
			end
			default: ;
		endcase
	end

	// Magnitude multiplier, one 16-bit digit of B per cycle, most significant first.
	logic [DIGIT_W-1:0]    mul_digit;
	logic [AW+DIGIT_W-1:0] mul_pp;

	assign mul_digit = b_q[BPW-1 -: DIGIT_W];
	assign mul_pp    = a_q * mul_digit;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= op_a;
			b_q   <= op_b;
			neg_q <= op_neg;
			acc_q <= '0;
		end else if (cmd.step) begin
			acc_q <= (acc_q << DIGIT_W) + PW'(mul_pp);
			b_q   <= b_q << DIGIT_W;
		end
	end

	// Signed product and its saturated forms.
	logic [RW-1:0]        acc_x;
	logic signed [RW-1:0] res;
	logic [PRW-1:0]       res_p;
	logic signed [63:0]   term_sat, prop_sat, add_sat;
	logic [64:0]          sum65;

	assign acc_x = {1'b0, acc_q};
	assign res   = neg_q ? $signed(~acc_x + 1'b1) : $signed(acc_x);
	assign res_p = {res, 8'h00};

	assign term_sat = ((&res[RW-1:63]) || !(|res[RW-1:63])) ? res[63:0]
	                : (res[RW-1] ? SAT_MIN : SAT_MAX);
	assign prop_sat = ((&res_p[PRW-1:63]) || !(|res_p[PRW-1:63])) ? res_p[63:0]
	                : (res_p[PRW-1] ? SAT_MIN : SAT_MAX);
	assign sum65    = {pid_q[63], pid_q} + {term_sat[63], term_sat};
	assign add_sat  = (sum65[64] != sum65[63]) ? (sum65[64] ? SAT_MIN : SAT_MAX)
	                : sum65[63:0];

	// Integral update with clamp.
	logic signed [RW-1:0]      inc;
	logic signed [SW-1:0]      integ_sum, integ_clamp;
	logic signed [INTEG_W-1:0] integ_new;

	assign inc         = res >>> 8;
	assign integ_sum   = $signed({{(SW-INTEG_W){integ_q[INTEG_W-1]}}, integ_q})
	                   + $signed({inc[RW-1], inc});
	assign integ_clamp = (integ_sum > ILIM_P) ? ILIM_P
	                   : ((integ_sum < ILIM_N) ? ILIM_N : integ_sum);
	assign integ_new   = integ_clamp[INTEG_W-1:0];

	// Derivative: the three-point form is halved with floor rounding.
	logic signed [RW-1:0]  deriv_half;
	logic signed [DRW-1:0] deriv_new;

	assign deriv_half = res >>> 1;
	assign deriv_new  = hist_q[1] ? deriv_half[DRW-1:0] : res[DRW-1:0];

	// New limit, saturated at 1.0.
	logic [LW-1:0]      lim_full;
	logic [LIMIT_W-1:0] held_new;

	assign lim_full = res[PW-1:32];
	assign held_new = (lim_full > LW'(LIMIT_ONE)) ? LIMIT_W'(LIMIT_ONE) : lim_full[LIMIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q  <= '0;
			last_q   <= '0;
			before_q <= '0;
			hist_q   <= '0;
			held_q   <= LIMIT_W'(LIMIT_ONE);
		end else if (cmd.write) begin
			case (cmd.op)
				OP_INC: integ_q <= integ_new;
				OP_DRV: begin
					before_q <= last_q;
					last_q   <= err;
					if (!hist_q[1]) begin
						hist_q <= hist_q + 2'd1;
					end
				end
				OP_LIM: held_q <= held_new;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			case (cmd.op)
				OP_DRV: deriv_q <= deriv_new;
				OP_PRP: pid_q   <= prop_sat;
				OP_INT: pid_q   <= add_sat;
				OP_DER: pid_q   <= add_sat;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_limit_q <= held_q;
			out_upd_q   <= ~status.skip;
		end
	end

	assign m_tdata = out_limit_q;
	assign m_tuser = out_upd_q;

endmodule

`default_nettype wire

FILE: rtl/core/thermal_pid_light_limiter.sv
// Top level of the thermal PID light limiter.
// Joins tpll_ctrl and tpll_datapath; uses tpll_pkg.
//
// Usage: each request on the slave stream is one periodic sample. s_tdata
// carries the signed Q8.8 temperature in its low TEMP_WIDTH bits and the
// Q0.16 light level above it. Every sample yields exactly one request on the
// master stream: m_tdata is the Q1.15 light limit and m_tuser is high when the
// level met the activation threshold and the limit was recomputed.
// Configuration is written through cfg_we / cfg_index / cfg_data, one register
// per cycle, while no sample is in flight.
// Operation: the block works on one sample at a time. A recomputed sample runs
// six products through one shared multiplier that takes a 16-bit digit per
// cycle, so each product needs ND digits with ND = ceil(max(GAIN_WIDTH,24)/16).
// Each product is loaded, stepped digit by digit and written back; after the
// sixth the result is registered, and the next sample can be taken in the same
// cycle as it appears. A sample below the threshold returns the held limit.
// Reset clears the loop state, sets the limit to 1.0 and loads the register
// defaults. The result sits in an output register: while the receiver stalls
// it holds, and one more sample can be accepted and worked on meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module thermal_pid_light_limiter #(
	parameter int TEMP_WIDTH = 16,
	parameter int GAIN_WIDTH = 32,
	localparam int CW1   = (TEMP_WIDTH > GAIN_WIDTH) ? TEMP_WIDTH : GAIN_WIDTH,
	localparam int CFG_W = (CW1 > tpll_pkg::INV_W) ? CW1 : tpll_pkg::INV_W,
	localparam int IN_W  = ((TEMP_WIDTH + tpll_pkg::LEVEL_W + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tpll_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]                cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_W-1:0]                 s_tdata,   // temperature, light_level
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tpll_pkg::LIMIT_W-1:0]    m_tdata,   // light_limit
	output logic                            m_tuser    // limit_updated
);
	import tpll_pkg::*;

	// Multiplier digits per product: enough for the widest B operand.
	localparam int BW = (GAIN_WIDTH > INV_W) ? GAIN_WIDTH : INV_W;
	localparam int ND = (BW + DIGIT_W - 1) / DIGIT_W;

	dp_cmd_t    cmd;
	dp_status_t status;

	tpll_ctrl #(
		.NUM_DIGITS (ND)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tpll_datapath #(
		.TEMP_WIDTH (TEMP_WIDTH),
		.GAIN_WIDTH (GAIN_WIDTH),
		.NUM_DIGITS (ND),
		.CFG_W      (CFG_W),
		.IN_W       (IN_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

FILE: rtl/core/tpll_checker.sv
// Port-level checks for the thermal PID light limiter, bound to the top level.
// Sees only the top-level ports; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module tpll_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// The limit never exceeds 1.0.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= 16'd32768)
		else $error("light limit above 1.0");

	// One sample at a time: after an accept the input side is closed.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// No result appears in the cycle right after an accept on an idle output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind thermal_pid_light_limiter tpll_checker u_chk (.*);

`default_nettype wire
